// ===== src/slt_pkg.sv =====
// slt_pkg: shared codes, field widths and cell control types for sorted_list_table
// no dependencies
`default_nettype none

package slt_pkg;

  localparam int unsigned ActionW = 3;
  localparam int unsigned PosW    = 5;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  localparam logic [ActionW-1:0] ActSortIns = 3'd0;
  localparam logic [ActionW-1:0] ActPosIns  = 3'd1;
  localparam logic [ActionW-1:0] ActDelete  = 3'd2;
  localparam logic [ActionW-1:0] ActRead    = 3'd3;
  localparam logic [ActionW-1:0] ActClear   = 3'd4;

  localparam logic [StatusW-1:0] StOk    = 2'd0;
  localparam logic [StatusW-1:0] StFull  = 2'd1;
  localparam logic [StatusW-1:0] StEmpty = 2'd2;
  localparam logic [StatusW-1:0] StRange = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS_SORT,
    CELL_INS_POS,
    CELL_DELETE
  } cell_op_e;

  typedef struct packed {
    cell_op_e                 op;
    logic signed [ValueW-1:0] value;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== src/slt_in_if.sv =====
// slt_in_if: request channel of sorted_list_table, valid/ready with payload
// depends on slt_pkg
`default_nettype none

interface slt_in_if;
  import slt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [ActionW-1:0]        action;
  logic [PosW-1:0]           position;
  logic signed [ValueW-1:0]  value;

  modport source (output valid, action, position, value, input ready);
  modport sink   (input valid, action, position, value, output ready);
endinterface

`default_nettype wire

// ===== src/slt_out_if.sv =====
// slt_out_if: result channel of sorted_list_table, valid/ready with payload
// depends on slt_pkg
`default_nettype none

interface slt_out_if;
  import slt_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [StatusW-1:0]        status;
  logic signed [ValueW-1:0]  read_value;
  logic [CountW-1:0]         entry_count;

  modport source (output valid, status, read_value, entry_count, input ready);
  modport sink   (input valid, status, read_value, entry_count, output ready);
endinterface

`default_nettype wire

// ===== src/slt_cell.sv =====
// slt_cell: one list entry; compares, shifts from its neighbors and forwards reads
// depends on slt_pkg
`default_nettype none

module slt_cell #(
  parameter int unsigned Index = 0,
  parameter int unsigned CmpW  = 5
) (
  input  wire                           clk_i,
  input  slt_pkg::cell_ctrl_t           ctrl_i,
  input  wire [CmpW-1:0]                pos_i,
  input  wire [CmpW-1:0]                count_i,
  input  wire signed [slt_pkg::ValueW-1:0] left_i,
  input  wire signed [slt_pkg::ValueW-1:0] right_i,
  input  wire                           all_lt_i,
  output logic                          all_lt_o,
  input  wire signed [slt_pkg::ValueW-1:0] rd_i,
  output logic signed [slt_pkg::ValueW-1:0] rd_o,
  output logic signed [slt_pkg::ValueW-1:0] entry_o
);
  import slt_pkg::*;

  localparam logic [CmpW-1:0] IdxL = CmpW'(Index);

  logic signed [ValueW-1:0] entry_q, entry_d;
  logic                     lt;

  assign lt       = (IdxL < count_i) && (entry_q < ctrl_i.value);
  assign all_lt_o = all_lt_i && lt;
  assign rd_o     = (IdxL == pos_i) ? entry_q : rd_i;
  assign entry_o  = entry_q;

  always_comb begin
    entry_d = entry_q;
    case (ctrl_i.op)
      CELL_INS_SORT: begin
        if (!all_lt_i) begin
          entry_d = left_i;
        end else if (!lt) begin
          entry_d = ctrl_i.value;
        end
      end
      CELL_INS_POS: begin
        if (IdxL == pos_i) begin
          entry_d = ctrl_i.value;
        end else if (IdxL > pos_i) begin
          entry_d = left_i;
        end
      end
      CELL_DELETE: begin
        if (IdxL >= pos_i) begin
          entry_d = right_i;
        end
      end
      default: entry_d = entry_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

`default_nettype wire

// ===== src/sorted_list_table.sv =====
// sorted_list_table: bounded ordered list of signed 32-bit values in a row of cells
// depends on slt_pkg, slt_in_if, slt_out_if, slt_cell
//
// Usage: requests arrive on in_i (action, position, value); each produces exactly
// one result on out_o (status, read_value, entry_count). Actions are sorted insert,
// insert at position, delete at position, read at position and clear.
// The result is registered and appears in the cycle after the request transfer.
// Throughput: one request per cycle while results are taken; each cell compares its
// entry with the broadcast value and takes its left or right neighbor in the same
// cycle; the insertion point ripples through the cells and reads pass down the row.
// The result sits in an output register; a new request is taken while that register
// is empty or being emptied, so a stalled receiver holds off requests after one.
// Reset clears the entry count and the output valid; entry contents are not reset
// and no clearing pass is needed.
`default_nettype none

module sorted_list_table #(
  parameter int unsigned DEPTH = 16
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  slt_in_if.sink     in_i,
  slt_out_if.source  out_o
);
  import slt_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > PosW) ? CntW : PosW;
  localparam logic [CmpW-1:0] DepthL = CmpW'(DEPTH);

  logic [CntW-1:0]          count_q, count_d;
  logic                     ovalid_q;
  logic [StatusW-1:0]       status_q, status_d;
  logic signed [ValueW-1:0] rd_q, rd_d;
  logic [CountW-1:0]        ocount_q;

  logic                     accept;
  logic [CmpW-1:0]          count_ext, pos_ext, cell_pos;
  cell_ctrl_t               ctrl;

  logic signed [ValueW-1:0] entry [DEPTH];
  logic signed [ValueW-1:0] rd_chain [DEPTH+1];
  logic                     lt_chain [DEPTH+1];

  assign in_i.ready = !ovalid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;
  assign count_ext  = CmpW'(count_q);
  assign pos_ext    = CmpW'(in_i.position);

  always_comb begin
    ctrl.op    = CELL_HOLD;
    ctrl.value = in_i.value;
    cell_pos   = pos_ext;
    count_d    = count_q;
    status_d   = StOk;
    rd_d       = '0;
    unique case (in_i.action)
      ActSortIns: begin
        if (count_ext >= DepthL) begin
          status_d = StFull;
        end else begin
          ctrl.op = CELL_INS_SORT;
          count_d = count_q + CntW'(1);
        end
      end
      ActPosIns: begin
        if (count_q == '0) begin
          status_d = StEmpty;
        end else if (count_ext >= DepthL) begin
          status_d = StFull;
        end else begin
          ctrl.op  = CELL_INS_POS;
          cell_pos = (pos_ext < count_ext) ? pos_ext : count_ext;
          count_d  = count_q + CntW'(1);
        end
      end
      ActDelete: begin
        if (count_q == '0) begin
          status_d = StEmpty;
        end else if (pos_ext >= count_ext) begin
          status_d = StRange;
        end else begin
          ctrl.op = CELL_DELETE;
          count_d = count_q - CntW'(1);
        end
      end
      ActRead: begin
        if (count_q == '0) begin
          status_d = StEmpty;
        end else if (pos_ext >= count_ext) begin
          status_d = StRange;
        end else begin
          rd_d = rd_chain[DEPTH];
        end
      end
      ActClear: begin
        count_d = '0;
      end
      default: begin
        status_d = StOk;
      end
    endcase
    if (!accept) begin
      ctrl.op = CELL_HOLD;
    end
  end

  assign rd_chain[0] = '0;
  assign lt_chain[0] = 1'b1;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [ValueW-1:0] left_w, right_w;
    if (g == 0) begin : g_first
      assign left_w = in_i.value;
    end else begin : g_mid_l
      assign left_w = entry[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right_w = entry[g];
    end else begin : g_mid_r
      assign right_w = entry[g+1];
    end

    slt_cell #(
      .Index (g),
      .CmpW  (CmpW)
    ) u_cell (
      .clk_i    (clk_i),
      .ctrl_i   (ctrl),
      .pos_i    (cell_pos),
      .count_i  (count_ext),
      .left_i   (left_w),
      .right_i  (right_w),
      .all_lt_i (lt_chain[g]),
      .all_lt_o (lt_chain[g+1]),
      .rd_i     (rd_chain[g]),
      .rd_o     (rd_chain[g+1]),
      .entry_o  (entry[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q  <= count_d;
        ovalid_q <= 1'b1;
      end else if (out_o.ready) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      rd_q     <= rd_d;
      ocount_q <= CountW'(CmpW'(count_d));
    end
  end

  assign out_o.valid       = ovalid_q;
  assign out_o.status      = status_q;
  assign out_o.read_value  = rd_q;
  assign out_o.entry_count = ocount_q;

endmodule

`default_nettype wire
